/* sv/mwt_pkg.sv */
`default_nettype none
package mwt_pkg;

    localparam int WINDOW = 4;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_TOTAL   = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_TIMEOUT = 3'd4;

    localparam logic [15:0] TOTAL_RST   = 16'd0;
    localparam logic [23:0] TIMEOUT_RST = 24'd3000;

    typedef enum logic [2:0] {
        OP_START  = 3'd0,
        OP_STOP   = 3'd1,
        OP_TOGGLE = 3'd2,
        OP_DONE   = 3'd3,
        OP_CANCEL = 3'd4,
        OP_TICK   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        KIND_ISSUE  = 2'd0,
        KIND_POS    = 2'd1,
        KIND_STOP   = 2'd2,
        KIND_STATUS = 2'd3
    } t_kind;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] from_unit;
        logic [15:0]        reply_mark;
        logic               speech_ok;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] unit_index;
        logic [15:0] unit_mark;
        logic        interrupt_flag;
        logic        consumed;
        logic        reading;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [15:0] mark;
        logic [15:0] unit;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage
`default_nettype wire

/* sv/mwt_cell.sv */
`default_nettype none
module mwt_cell (
    input  wire logic              i_clk,
    input  wire mwt_pkg::t_cell_ctl i_ctl,
    input  wire mwt_pkg::t_entry   i_next,
    input  wire mwt_pkg::t_entry   i_load,
    input  wire logic [15:0]       i_reply_mark,
    output mwt_pkg::t_entry        o_entry,
    output logic                   o_match
);
    import mwt_pkg::*;

    t_entry r_entry;

    // shift towards the head has priority, loading only happens while filling
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_next;
        end else if (i_ctl.load) begin
            r_entry <= i_load;
        end
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry.mark == i_reply_mark);

endmodule
`default_nettype wire

/* sv/marked_unit_window_tracker.sv */
// busy stays high until the status result shows; a new request is taken while status shows
// one request at a time, set by the sequencer stepping the cell chain
// one result per cycle at most, each shown for a single cycle on o_res_valid; receiver cannot stall
// the status result is always the last one of a request
// synchronous active-low reset clears control state and loads register reset values
`default_nettype none
module marked_unit_window_tracker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire mwt_pkg::t_req                 i_req,
    output logic                               o_res_valid,
    output mwt_pkg::t_res                      o_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mwt_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import mwt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_SHIFT  = 7'b0000100,
        S_HEAD   = 7'b0001000,
        S_FILL   = 7'b0010000,
        S_POS    = 7'b0100000,
        S_STATUS = 7'b1000000
    } t_state;

    // configuration
    logic [15:0] r_total;
    logic [23:0] r_timeout;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= TOTAL_RST;
            r_timeout <= TIMEOUT_RST;
        end else if (cfg_wr) begin
            if (paddr == ADDR_TOTAL) begin
                r_total <= pwdata[15:0];
            end
            if (paddr == ADDR_TIMEOUT) begin
                r_timeout <= pwdata[23:0];
            end
        end
    end

    always_comb begin
        unique case (paddr)
            ADDR_TOTAL:   prdata = {16'd0, r_total};
            ADDR_TIMEOUT: prdata = {8'd0, r_timeout};
            default:      prdata = 32'd0;
        endcase
    end

    // control state
    t_state           r_state, n_state;
    t_req             r_req;
    logic             r_active, n_active;
    logic [15:0]      r_next_pos, n_next_pos;
    logic [15:0]      r_mark, n_mark;
    logic [CNT_W-1:0] r_count, n_count;
    logic [23:0]      r_ticks, n_ticks;
    logic [CNT_W-1:0] r_shift, n_shift;
    logic [15:0]      r_from, n_from;
    logic             r_intr, n_intr;
    logic             r_is_start, n_is_start;
    logic             r_cons, n_cons;
    logic             r_out_valid, n_out_valid;
    t_res             r_out, n_out;

    // cell chain
    t_entry    cell_q   [WINDOW];
    logic      cell_hit [WINDOW];
    t_cell_ctl cell_ctl [WINDOW];
    t_entry    load_entry;
    logic      do_shift;
    logic      do_load;

    genvar g;
    generate
        for (g = 0; g < WINDOW; g++) begin : g_cell
            t_entry nb;
            if (g == WINDOW - 1) begin : g_tail
                assign nb = '0;
            end else begin : g_mid
                assign nb = cell_q[g+1];
            end
            assign cell_ctl[g].shift = do_shift;
            assign cell_ctl[g].load  = do_load && (r_count == CNT_W'(g));
            mwt_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl[g]),
                .i_next       (nb),
                .i_load       (load_entry),
                .i_reply_mark (r_req.reply_mark),
                .o_entry      (cell_q[g]),
                .o_match      (cell_hit[g])
            );
        end
    endgenerate

    // first outstanding entry carrying the reply mark
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = WINDOW - 1; i >= 0; i--) begin
            if (cell_hit[i] && (CNT_W'(i) < r_count)) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    logic [15:0] mark_inc;
    logic [15:0] from_clamped;
    logic        go_start;
    logic        go_stop;

    always_comb begin
        mark_inc = r_mark + 16'd1;
        if (mark_inc == 16'd0) begin
            mark_inc = 16'd1;
        end
    end

    assign from_clamped = r_req.from_unit[15] ? 16'd0 : r_req.from_unit;
    assign load_entry   = '{mark: mark_inc, unit: r_next_pos};
    assign go_start = (r_req.opcode == OP_START) || (r_req.opcode == OP_TOGGLE && !r_active);
    assign go_stop  = (r_req.opcode == OP_STOP) || (r_req.opcode == OP_TOGGLE && r_active);

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_next_pos  = r_next_pos;
        n_mark      = r_mark;
        n_count     = r_count;
        n_ticks     = r_ticks;
        n_shift     = r_shift;
        n_from      = r_from;
        n_intr      = r_intr;
        n_is_start  = r_is_start;
        n_cons      = r_cons;
        n_out_valid = 1'b0;
        n_out       = r_out;
        do_shift    = 1'b0;
        do_load     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_cons     = 1'b0;
                n_is_start = 1'b0;
                n_state    = S_STATUS;
                if (go_start) begin
                    n_active   = 1'b1;
                    n_count    = '0;
                    n_next_pos = from_clamped;
                    n_from     = from_clamped;
                    n_intr     = 1'b1;
                    n_is_start = 1'b1;
                    n_state    = S_FILL;
                end else if (go_stop) begin
                    if (r_active) begin
                        n_active    = 1'b0;
                        n_count     = '0;
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        n_out.kind  = KIND_STOP;
                    end
                end else if (r_req.opcode == OP_DONE || r_req.opcode == OP_CANCEL) begin
                    if (r_active && hit) begin
                        n_cons = 1'b1;
                        if (r_req.opcode == OP_CANCEL) begin
                            n_active = 1'b0;
                            n_count  = '0;
                        end else begin
                            n_shift = CNT_W'(hit_idx) + CNT_W'(1);
                            n_intr  = 1'b0;
                            n_state = S_SHIFT;
                        end
                    end
                end else if (r_req.opcode == OP_TICK) begin
                    if (r_active) begin
                        if (r_ticks == 24'd0) begin
                            n_active = 1'b0;
                            n_count  = '0;
                        end else begin
                            n_ticks = r_ticks - 24'd1;
                        end
                    end
                end
            end
            S_SHIFT: begin
                // retire one entry per cycle up to the matched one
                do_shift = 1'b1;
                n_count  = r_count - CNT_W'(1);
                n_shift  = r_shift - CNT_W'(1);
                if (r_shift == CNT_W'(1)) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (r_count != '0) begin
                    n_out_valid      = 1'b1;
                    n_out            = '0;
                    n_out.kind       = KIND_POS;
                    n_out.unit_index = cell_q[0].unit;
                end
                n_state = S_FILL;
            end
            S_FILL: begin
                if (!r_active || r_count == CNT_W'(WINDOW) || r_next_pos >= r_total) begin
                    if (r_count == '0) begin
                        n_active = 1'b0;
                    end
                    n_state = r_is_start ? S_POS : S_STATUS;
                end else begin
                    n_mark = mark_inc;
                    if (!r_req.speech_ok) begin
                        // refused issue still uses up a mark
                        n_active = 1'b0;
                        n_count  = '0;
                        n_state  = r_is_start ? S_POS : S_STATUS;
                    end else begin
                        do_load              = 1'b1;
                        n_out_valid          = 1'b1;
                        n_out                = '0;
                        n_out.kind           = KIND_ISSUE;
                        n_out.unit_index     = r_next_pos;
                        n_out.unit_mark      = mark_inc;
                        n_out.interrupt_flag = r_intr;
                        n_intr               = 1'b0;
                        n_count              = r_count + CNT_W'(1);
                        n_next_pos           = r_next_pos + 16'd1;
                        n_ticks              = r_timeout;
                    end
                end
            end
            S_POS: begin
                if (r_active) begin
                    n_out_valid      = 1'b1;
                    n_out            = '0;
                    n_out.kind       = KIND_POS;
                    n_out.unit_index = r_from;
                end
                n_state = S_STATUS;
            end
            S_STATUS: begin
                n_out_valid    = 1'b1;
                n_out          = '0;
                n_out.kind     = KIND_STATUS;
                n_out.consumed = r_cons;
                n_out.reading  = r_active;
                n_out.last     = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_next_pos  <= '0;
            r_mark      <= '0;
            r_count     <= '0;
            r_ticks     <= '0;
            r_shift     <= '0;
            r_intr      <= 1'b0;
            r_is_start  <= 1'b0;
            r_cons      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_next_pos  <= n_next_pos;
            r_mark      <= n_mark;
            r_count     <= n_count;
            r_ticks     <= n_ticks;
            r_shift     <= n_shift;
            r_intr      <= n_intr;
            r_is_start  <= n_is_start;
            r_cons      <= n_cons;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_from <= n_from;
        r_out  <= n_out;
        if (r_state == S_IDLE && start) begin
            r_req <= i_req;
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule
`default_nettype wire
